@@ rtl/srw_pkg.sv @@
package srw_pkg;

    // sizing
    localparam int SEQ_BITS_MAX   = 4;
    localparam int WIN_MAX        = 1 << (SEQ_BITS_MAX - 1);
    localparam int SEQ_W          = SEQ_BITS_MAX;
    localparam int IDX_W          = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
    localparam int CNT_W          = $clog2(WIN_MAX + 1);
    localparam int ACT_W          = $clog2(SEQ_BITS_MAX + 1);
    localparam int CFG_W          = 3;
    localparam int RESET_SEQ_BITS = 3;

    // field widths on the ports
    localparam int SEQ_F_W  = 4;
    localparam int SLOT_F_W = 3;
    localparam int EV_F_W   = 3;

    typedef logic [SEQ_W-1:0] seq_t;
    typedef logic [ACT_W-1:0] act_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        MODE_OUTCOME = 2'd0,
        MODE_SLIDE   = 2'd1,
        MODE_RESTART = 2'd2
    } mode_t;

    typedef enum logic [EV_F_W-1:0] {
        EV_ACCEPTED  = 3'd0,
        EV_DUPLICATE = 3'd1,
        EV_NAK       = 3'd2,
        EV_LOST      = 3'd3,
        EV_ACKED     = 3'd4,
        EV_SEND      = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_LOAD    = 2'd1,
        CELL_SHIFT   = 2'd2,
        CELL_OUTCOME = 2'd3
    } cell_op_t;

    // control broadcast to every cell of the window
    typedef struct packed {
        cell_op_t op;
        seq_t     recv_next;
        logic     set_ack;
        seq_t     inj_seq;
        logic     inj_acked;
    } cell_ctrl_t;

    // out-of-range sequence widths are pulled into range
    function automatic act_t clamp_bits(input logic [CFG_W-1:0] b);
        act_t r;
        if (b == '0) begin
            r = act_t'(1);
        end else if (int'(b) > SEQ_BITS_MAX) begin
            r = act_t'(SEQ_BITS_MAX);
        end else begin
            r = act_t'(b);
        end
        return r;
    endfunction

    function automatic cnt_t win_of(input act_t act);
        return cnt_t'(1) << (act - act_t'(1));
    endfunction

    function automatic seq_t mask_of(input act_t act);
        logic [SEQ_W:0] t;
        t = (SEQ_W + 1)'(1) << act;
        return seq_t'(t - (SEQ_W + 1)'(1));
    endfunction

endpackage

@@ rtl/srw_cell.sv @@
module srw_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  srw_pkg::cell_ctrl_t ctrl,
    input  srw_pkg::seq_t      probe,
    input  srw_pkg::seq_t      load_val,
    input  srw_pkg::seq_t      right_send,
    input  logic               right_acked,
    input  logic               in_win,
    input  logic               is_tail,
    input  logic               is_slot,
    input  logic               found_in,
    output srw_pkg::seq_t      send_q,
    output logic               acked_q,
    output logic               found_out
);
    import srw_pkg::*;

    seq_t send_reg;
    seq_t exp_reg;
    logic acked_reg;
    logic match;
    logic hit;
    seq_t src_send;
    logic src_acked;

    // receiver slot search, first match along the row wins
    assign match     = in_win && (exp_reg == probe);
    assign hit       = match && !found_in;
    assign found_out = found_in || match;

    // the tail of the window takes the injected entry, the rest the right neighbour
    assign src_send  = is_tail ? ctrl.inj_seq   : right_send;
    assign src_acked = is_tail ? ctrl.inj_acked : right_acked;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_reg  <= load_val;
            exp_reg   <= load_val;
            acked_reg <= 1'b0;
        end else begin
            case (ctrl.op)
                CELL_LOAD: begin
                    send_reg  <= load_val;
                    exp_reg   <= load_val;
                    acked_reg <= 1'b0;
                end
                CELL_SHIFT: begin
                    send_reg  <= src_send;
                    acked_reg <= src_acked;
                end
                CELL_OUTCOME: begin
                    if (hit) begin
                        exp_reg <= ctrl.recv_next;
                    end
                    if (is_slot && ctrl.set_ack) begin
                        acked_reg <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign send_q  = send_reg;
    assign acked_q = acked_reg;

endmodule

@@ rtl/selective_repeat_window_unit.sv @@
// Selective-repeat window pair: sender and receiver windows of W = 2^(n-1)
// slots over sequence numbers modulo 2^n, held in a row of window cells.
// Input channel s_*: one transfer per item (frame outcome, slide, restart).
// Result channel m_*: one or more transfers per item, m_tlast on the final one;
// an outcome naming a slot outside the window, or the unused mode, gives none.
// cfg_wr_en/cfg_wr_data write the sequence width n; it takes effect at the next
// restart item. An outcome item gives its single result straight into the output
// register. A restart reloads both windows and lists every slot. A slide drops the
// leading acknowledged slots, the row shifting left one slot a cycle, then rotates
// once round the window, one slot a cycle while the output register is free,
// listing each unacknowledged slot as a frame to send. s_tready stays low until
// the listing is done.
// Reset: both windows hold 0..3 (n = 3), nothing acknowledged, no result
// pending. A stalled m_tready holds the result and freezes the rotation;
// no result is lost or repeated.
module selective_repeat_window_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,  // seq_bits
    // items in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // mode[1:0], slot[4:2], arrived[5], damaged[6],
                                      // ack_lost[7]
    // results out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // seq[3:0], slot_out[6:4], event_code[9:7],
                                      // ack_received[10], zero fill
    output logic        m_tlast
);
    import srw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SHIFT = 3'b010,
        ST_LIST  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     cfg_bits_reg;
    act_t                 act_bits_reg, act_bits_next;
    seq_t                 send_next_reg, send_next_next;
    seq_t                 recv_next_reg, recv_next_next;
    logic [IDX_W-1:0]     rot_cnt_reg, rot_cnt_next;
    cnt_t                 emit_left_reg, emit_left_next;

    logic                 m_valid_reg;
    logic [SEQ_F_W-1:0]   m_seq_reg;
    logic [SLOT_F_W-1:0]  m_slot_reg;
    event_t               m_ev_reg;
    logic                 m_ack_reg;
    logic                 m_last_reg;

    logic                 emit;
    logic [SEQ_F_W-1:0]   o_seq;
    logic [SLOT_F_W-1:0]  o_slot;
    event_t               o_ev;
    logic                 o_ack;
    logic                 o_last;

    cell_ctrl_t           ctrl;
    seq_t                 probe;
    logic                 out_free;
    logic                 take;

    mode_t                in_mode;
    logic [2:0]           in_slot;
    logic                 in_arrived;
    logic                 in_damaged;
    logic                 in_ack_lost;

    cnt_t                 win;
    seq_t                 mask;
    act_t                 load_bits;
    cnt_t                 load_win;
    logic [IDX_W-1:0]     slot_idx;
    logic                 slot_ok;
    logic                 probe_acked;

    seq_t                 cell_send  [WIN_MAX];
    logic                 cell_acked [WIN_MAX];
    seq_t                 load_val   [WIN_MAX];
    logic                 found      [WIN_MAX+1];
    logic [WIN_MAX-1:0]   in_win;
    logic [WIN_MAX-1:0]   unacked;

    // input fields
    assign in_mode     = mode_t'(s_tdata[1:0]);
    assign in_slot     = s_tdata[4:2];
    assign in_arrived  = s_tdata[5];
    assign in_damaged  = s_tdata[6];
    assign in_ack_lost = s_tdata[7];

    // window geometry
    assign win       = win_of(act_bits_reg);
    assign mask      = mask_of(act_bits_reg);
    assign load_bits = aresetn ? clamp_bits(cfg_bits_reg) : clamp_bits(CFG_W'(RESET_SEQ_BITS));
    assign load_win  = win_of(load_bits);

    // sender slot named by an outcome
    assign slot_idx    = IDX_W'(in_slot);
    assign slot_ok     = int'(in_slot) < int'(win);
    assign probe       = cell_send[slot_idx];
    assign probe_acked = cell_acked[slot_idx];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign take     = s_tvalid && s_tready;

    // row of window cells
    assign found[0] = 1'b0;
    genvar k;
    generate
        for (k = 0; k < WIN_MAX; k++) begin : g_cell
            seq_t r_send;
            logic r_acked;
            if (k == WIN_MAX - 1) begin : g_end
                assign r_send  = ctrl.inj_seq;
                assign r_acked = ctrl.inj_acked;
            end else begin : g_mid
                assign r_send  = cell_send[k+1];
                assign r_acked = cell_acked[k+1];
            end
            assign in_win[k]   = cnt_t'(k) < win;
            assign unacked[k]  = in_win[k] && !cell_acked[k];
            assign load_val[k] = (cnt_t'(k) < load_win) ? seq_t'(k) : '0;

            srw_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .probe       (probe),
                .load_val    (load_val[k]),
                .right_send  (r_send),
                .right_acked (r_acked),
                .in_win      (in_win[k]),
                .is_tail     (cnt_t'(k) == win - cnt_t'(1)),
                .is_slot     (slot_idx == IDX_W'(k)),
                .found_in    (found[k]),
                .send_q      (cell_send[k]),
                .acked_q     (cell_acked[k]),
                .found_out   (found[k+1])
            );
        end
    endgenerate

    // sequencing of items
    always_comb begin
        state_next     = state_reg;
        act_bits_next  = act_bits_reg;
        send_next_next = send_next_reg;
        recv_next_next = recv_next_reg;
        rot_cnt_next   = rot_cnt_reg;
        emit_left_next = emit_left_reg;

        ctrl.op        = CELL_HOLD;
        ctrl.recv_next = recv_next_reg;
        ctrl.set_ack   = !in_ack_lost;
        ctrl.inj_seq   = send_next_reg;
        ctrl.inj_acked = 1'b0;

        emit   = 1'b0;
        o_seq  = SEQ_F_W'(probe);
        o_slot = in_slot;
        o_ev   = EV_SEND;
        o_ack  = 1'b0;
        o_last = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    case (in_mode)
                        MODE_OUTCOME: begin
                            if (slot_ok) begin
                                emit = 1'b1;
                                if (probe_acked) begin
                                    o_ev = EV_ACKED;
                                end else if (in_arrived) begin
                                    ctrl.op = CELL_OUTCOME;
                                    o_ev    = found[WIN_MAX] ? EV_ACCEPTED : EV_DUPLICATE;
                                    o_ack   = !in_ack_lost;
                                    if (found[WIN_MAX]) begin
                                        recv_next_next = (recv_next_reg + seq_t'(1)) & mask;
                                    end
                                end else begin
                                    o_ev = in_damaged ? EV_NAK : EV_LOST;
                                end
                            end
                        end
                        MODE_SLIDE: begin
                            state_next = ST_SHIFT;
                        end
                        MODE_RESTART: begin
                            ctrl.op        = CELL_LOAD;
                            act_bits_next  = load_bits;
                            send_next_next = seq_t'(load_win) & mask_of(load_bits);
                            recv_next_next = seq_t'(load_win) & mask_of(load_bits);
                            rot_cnt_next   = '0;
                            emit_left_next = load_win;
                            state_next     = ST_LIST;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                // drop one leading acknowledged slot, fresh number at the tail
                if (cell_acked[0]) begin
                    ctrl.op        = CELL_SHIFT;
                    send_next_next = (send_next_reg + seq_t'(1)) & mask;
                end else begin
                    rot_cnt_next   = '0;
                    emit_left_next = cnt_t'($countones(unacked));
                    state_next     = ST_LIST;
                end
            end
            ST_LIST: begin
                // rotate once round the window, listing slot 0 each step if it is unacknowledged
                if (out_free) begin
                    ctrl.op        = CELL_SHIFT;
                    ctrl.inj_seq   = cell_send[0];
                    ctrl.inj_acked = cell_acked[0];
                    if (!cell_acked[0]) begin
                        emit           = 1'b1;
                        o_seq          = SEQ_F_W'(cell_send[0]);
                        o_slot         = SLOT_F_W'(rot_cnt_reg);
                        o_ev           = EV_SEND;
                        o_last         = (emit_left_reg == cnt_t'(1));
                        emit_left_next = emit_left_reg - cnt_t'(1);
                    end
                    rot_cnt_next = rot_cnt_reg + IDX_W'(1);
                    if (rot_cnt_reg == IDX_W'(win - cnt_t'(1))) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cfg_bits_reg  <= CFG_W'(RESET_SEQ_BITS);
            act_bits_reg  <= load_bits;
            send_next_reg <= seq_t'(load_win) & mask_of(load_bits);
            recv_next_reg <= seq_t'(load_win) & mask_of(load_bits);
            rot_cnt_reg   <= '0;
            emit_left_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            act_bits_reg  <= act_bits_next;
            send_next_reg <= send_next_next;
            recv_next_reg <= recv_next_next;
            rot_cnt_reg   <= rot_cnt_next;
            emit_left_reg <= emit_left_next;
            if (cfg_wr_en) begin
                cfg_bits_reg <= cfg_wr_data;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_seq_reg  <= o_seq;
            m_slot_reg <= o_slot;
            m_ev_reg   <= o_ev;
            m_ack_reg  <= o_ack;
            m_last_reg <= o_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_ack_reg, m_ev_reg, m_slot_reg, m_seq_reg};
    assign m_tlast  = m_last_reg;

endmodule

@@ rtl/srw_checker.sv @@
module srw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    import srw_pkg::*;

    // a stalled result transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // only the defined event codes leave the block
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[9:7] <= EV_SEND)
        else $error("undefined event code");

    // an acknowledgement only comes with an arrived frame
    a_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> m_tdata[9:7] == EV_ACCEPTED
                                 || m_tdata[9:7] == EV_DUPLICATE)
        else $error("acknowledgement on wrong event");

    // an outcome gives a single result, so it is always the last
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:7] != EV_SEND |-> m_tlast)
        else $error("outcome result without last");

endmodule

bind selective_repeat_window_unit srw_checker u_srw_checker (.*);

@@ sim/tb_selective_repeat_window_unit.sv @@
`timescale 1ns / 100ps

module tb_selective_repeat_window_unit;
    import srw_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PCT      = 16;

    // mode value with no meaning, the block drops it
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [3:0] seq;
        logic [2:0] slot;
        event_t     ev;
        logic       ack;
        logic       last;
    } frame_report_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [2:0]  cfg_wr_data = 3'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'd0;  // mode[1:0], slot[4:2], arrived[5], damaged[6],
                                      // ack_lost[7]
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;             // seq[3:0], slot_out[6:4], event_code[9:7],
                                      // ack_received[10], zero fill
    logic        m_tlast;

    selective_repeat_window_unit uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // shadow of the window pair
    logic [2:0]    cfg_bits;
    int            act_bits;
    logic [3:0]    seq_mask;
    logic [3:0]    slot_seq [8];
    logic          slot_acked [8];
    logic [3:0]    rx_expect [8];
    logic [3:0]    tx_next;
    logic [3:0]    rx_next;
    frame_report_t frame_reports_due [$];

    int            error_count  = 0;
    int            items_sent   = 0;
    int            reports_seen = 0;
    int            cycle_count  = 0;
    bit            idle_on      = 1'b1;
    bit            hold_req     = 1'b0;
    int            hold_left    = 0;
    frame_report_t got_report;
    frame_report_t want_report;

    // clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [7:0] pack_item(input logic [1:0] mode, input logic [2:0] slot,
                                             input logic arrived, input logic damaged,
                                             input logic ack_lost);
        return {ack_lost, damaged, arrived, slot, mode};
    endfunction

    function automatic frame_report_t make_report(input logic [3:0] sq, input logic [2:0] slot,
                                                  input event_t ev, input logic ack,
                                                  input logic last);
        frame_report_t r;
        r.seq  = sq;
        r.slot = slot;
        r.ev   = ev;
        r.ack  = ack;
        r.last = last;
        return r;
    endfunction

    // load both windows from the latched width
    task automatic reload_windows();
        int w;
        if (cfg_bits == 3'd0) begin
            act_bits = 1;
        end else if (int'(cfg_bits) > SEQ_BITS_MAX) begin
            act_bits = SEQ_BITS_MAX;
        end else begin
            act_bits = int'(cfg_bits);
        end
        w = 1 << (act_bits - 1);
        seq_mask = 4'((1 << act_bits) - 1);
        for (int k = 0; k < 8; k++) begin
            slot_seq[k]   = (k < w) ? 4'(k) : 4'd0;
            rx_expect[k]  = (k < w) ? 4'(k) : 4'd0;
            slot_acked[k] = 1'b0;
        end
        tx_next = 4'(w) & seq_mask;
        rx_next = 4'(w) & seq_mask;
    endtask

    // every unacknowledged slot becomes a frame to send
    task automatic list_pending();
        int w;
        int pend;
        int emitted;
        w = 1 << (act_bits - 1);
        pend = 0;
        emitted = 0;
        for (int k = 0; k < w; k++) begin
            if (!slot_acked[k]) pend++;
        end
        for (int k = 0; k < w; k++) begin
            if (!slot_acked[k]) begin
                emitted++;
                frame_reports_due.push_back(make_report(slot_seq[k], 3'(k), EV_SEND, 1'b0,
                                                        emitted == pend));
            end
        end
    endtask

    // update the window pair for one accepted item and queue its reports
    task automatic advance_windows(input logic [7:0] item);
        logic [1:0] mode;
        logic [2:0] slot;
        logic       arrived;
        logic       damaged;
        logic       ack_lost;
        int         w;
        int         lead;
        int         d;
        logic [3:0] sq;
        event_t     ev;
        logic       ack;
        {ack_lost, damaged, arrived, slot, mode} = item;
        w = 1 << (act_bits - 1);
        case (mode)
            MODE_OUTCOME: begin
                if (int'(slot) < w) begin
                    sq = slot_seq[slot];
                    ack = 1'b0;
                    if (slot_acked[slot]) begin
                        ev = EV_ACKED;
                    end else if (arrived) begin
                        ev = EV_DUPLICATE;
                        for (int j = 0; j < w; j++) begin
                            if (rx_expect[j] == sq) begin
                                rx_expect[j] = rx_next;
                                rx_next = (rx_next + 4'd1) & seq_mask;
                                ev = EV_ACCEPTED;
                                break;
                            end
                        end
                        if (!ack_lost) begin
                            slot_acked[slot] = 1'b1;
                            ack = 1'b1;
                        end
                    end else begin
                        ev = damaged ? EV_NAK : EV_LOST;
                    end
                    frame_reports_due.push_back(make_report(sq, slot, ev, ack, 1'b1));
                end
            end
            MODE_SLIDE: begin
                lead = w;
                for (int k = 0; k < w; k++) begin
                    if (!slot_acked[k]) begin
                        lead = k;
                        break;
                    end
                end
                d = 0;
                for (int k = lead; k < w; k++) begin
                    slot_seq[d]   = slot_seq[k];
                    slot_acked[d] = slot_acked[k];
                    d++;
                end
                for (int k = d; k < w; k++) begin
                    slot_seq[k]   = tx_next;
                    tx_next       = (tx_next + 4'd1) & seq_mask;
                    slot_acked[k] = 1'b0;
                end
                list_pending();
            end
            MODE_RESTART: begin
                reload_windows();
                list_pending();
            end
            default: begin
            end
        endcase
    endtask

    // one input transfer, with random gaps ahead of it
    task automatic send_item(input logic [7:0] item);
        @(negedge aclk);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        advance_windows(item);
    endtask

    // stop sending and wait for every outstanding report
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (frame_reports_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // width register write, only with the block idle
    task automatic set_width(input logic [2:0] bits);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= bits;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_bits = bits;
    endtask

    // mostly well-formed outcomes and slides, some noise
    function automatic logic [7:0] random_item();
        int         r;
        int         w;
        logic [2:0] slot;
        r = $urandom_range(0, 99);
        w = 1 << (act_bits - 1);
        if (r < 4) begin
            return {6'($urandom_range(0, 63)), MODE_UNUSED};
        end else if (r < 6) begin
            return {6'($urandom_range(0, 63)), MODE_RESTART};
        end else if (r < 20) begin
            return {6'($urandom_range(0, 63)), MODE_SLIDE};
        end
        slot = (r < 24) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, w - 1));
        return pack_item(MODE_OUTCOME, slot, $urandom_range(0, 99) < 70,
                         1'($urandom_range(0, 1)), $urandom_range(0, 99) < 25);
    endfunction

    // every outcome kind on the reset window
    task automatic test_outcome_events();
        send_item(pack_item(MODE_RESTART, 3'd0, 1'b0, 1'b0, 1'b0));
        send_item(pack_item(MODE_OUTCOME, 3'd0, 1'b1, 1'b0, 1'b0));
        send_item(pack_item(MODE_OUTCOME, 3'd0, 1'b1, 1'b0, 1'b0));
        send_item(pack_item(MODE_OUTCOME, 3'd1, 1'b1, 1'b0, 1'b1));
        send_item(pack_item(MODE_OUTCOME, 3'd1, 1'b1, 1'b0, 1'b0));
        send_item(pack_item(MODE_OUTCOME, 3'd2, 1'b0, 1'b1, 1'b0));
        send_item(pack_item(MODE_OUTCOME, 3'd3, 1'b0, 1'b0, 1'b1));
        // slot beyond the window and the spare mode are both dropped
        send_item(pack_item(MODE_OUTCOME, 3'd7, 1'b1, 1'b0, 1'b0));
        send_item(pack_item(MODE_UNUSED, 3'd7, 1'b1, 1'b1, 1'b1));
    endtask

    // partial slide, then a slide with the whole window acknowledged
    task automatic test_window_slide();
        send_item(pack_item(MODE_SLIDE, 3'd0, 1'b0, 1'b0, 1'b0));
        for (int k = 0; k < 4; k++) begin
            send_item(pack_item(MODE_OUTCOME, 3'(k), 1'b1, 1'b0, 1'b0));
        end
        send_item(pack_item(MODE_SLIDE, 3'd5, 1'b1, 1'b1, 1'b1));
    endtask

    // width register at zero and at its top, both pulled into range
    task automatic test_width_extremes();
        set_width(3'd0);
        send_item(pack_item(MODE_RESTART, 3'd0, 1'b0, 1'b0, 1'b0));
        send_item(pack_item(MODE_OUTCOME, 3'd0, 1'b1, 1'b0, 1'b0));
        send_item(pack_item(MODE_OUTCOME, 3'd1, 1'b1, 1'b0, 1'b0));
        send_item(pack_item(MODE_SLIDE, 3'd0, 1'b0, 1'b0, 1'b0));
        send_item(pack_item(MODE_OUTCOME, 3'd0, 1'b1, 1'b0, 1'b1));
        set_width(3'd7);
        send_item(pack_item(MODE_RESTART, 3'd0, 1'b0, 1'b0, 1'b0));
        send_item(pack_item(MODE_OUTCOME, 3'd7, 1'b1, 1'b1, 1'b1));
        send_item(pack_item(MODE_SLIDE, 3'd0, 1'b0, 1'b0, 1'b0));
    endtask

    // random traffic at one width, optional quiet stretch or mid-run pause
    task automatic test_random_traffic(input logic [2:0] bits, input int count,
                                       input bit quiet, input bit pause_mid);
        set_width(bits);
        idle_on = !quiet;
        send_item(pack_item(MODE_RESTART, 3'd0, 1'b0, 1'b0, 1'b0));
        for (int k = 0; k < count; k++) begin
            if (pause_mid && k == count / 2) drain_results();
            send_item(random_item());
        end
        drain_results();
        idle_on = 1'b1;
    endtask

    // long receiver stall at the widest window so the block backs up
    task automatic test_backpressure();
        set_width(3'd4);
        send_item(pack_item(MODE_RESTART, 3'd0, 1'b0, 1'b0, 1'b0));
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++) begin
            send_item(random_item());
        end
        drain_results();
    endtask

    // receiver side: random stalls, or a counted hold when asked
    always @(negedge aclk) begin
        if (hold_left == 0 && hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // compare each result transfer with the oldest report due
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            reports_seen++;
            got_report = make_report(m_tdata[3:0], m_tdata[6:4], event_t'(m_tdata[9:7]),
                                     m_tdata[10], m_tlast);
            if (frame_reports_due.size() == 0) begin
                error_count++;
                $display("%0t: unexpected report seq %0d slot %0d event %0d ack %b last %b",
                         $time, got_report.seq, got_report.slot, got_report.ev,
                         got_report.ack, got_report.last);
            end else begin
                want_report = frame_reports_due.pop_front();
                if (got_report !== want_report) begin
                    error_count++;
                    $display("%0t: mismatch expected seq %0d slot %0d event %0d ack %b last %b",
                             $time, want_report.seq, want_report.slot, want_report.ev,
                             want_report.ack, want_report.last);
                    $display("%0t:            actual seq %0d slot %0d event %0d ack %b last %b",
                             $time, got_report.seq, got_report.slot, got_report.ev,
                             got_report.ack, got_report.last);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d reports outstanding",
                     $time, cycle_count, frame_reports_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // test sequence
    initial begin
        cfg_bits = 3'd3;
        reload_windows();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_outcome_events();
        test_window_slide();
        test_width_extremes();
        test_random_traffic(3'd1, 40, 1'b0, 1'b0);
        test_random_traffic(3'd2, 40, 1'b0, 1'b1);
        test_backpressure();
        test_random_traffic(3'd5, 40, 1'b1, 1'b0);
        test_random_traffic(3'd6, 40, 1'b0, 1'b0);
        test_random_traffic(3'($urandom_range(0, 7)), 40, 1'b0, 1'b0);
        drain_results();

        $display("%0d items in, %0d frame reports checked, %0d errors", items_sent,
                 reports_seen, error_count);
        $display("covered outcomes, slides, restarts and dropped items at widths 1 to 4");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
